[hw/rtl/lasm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_pkg
// Shared constants, codes and types for the local alignment score block.
// ----------------------------------------------------------------------------
package lasm_pkg;

  // sizes
  localparam int MAX_QUERY_LEN = 64;
  localparam int LEN_W         = $clog2(MAX_QUERY_LEN + 1);
  localparam int SYM_W         = 8;
  localparam int SCORE_W       = 10;
  localparam int MATCH_W       = 4;
  localparam int PEN_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CALC_W        = SCORE_W + 2;
  localparam int SCORE_CAP     = (1 << SCORE_W) - 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

  // item opcodes
  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_APPEND    = 2'd1,
    OP_REFERENCE = 2'd2
  } opcode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAVE,
    ST_LOAD,
    ST_UNLOAD
  } state_t;

  // wavefront data handed from one row cell to the next
  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   ref_sym;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] above;
  } wave_t;

  // control and scoring settings shared by every cell
  typedef struct packed {
    logic               clear;
    logic               load_out;
    logic               shift_out;
    logic [MATCH_W-1:0] match;
    logic [PEN_W-1:0]   mismatch;
    logic [PEN_W-1:0]   gap;
  } cell_ctl_t;

endpackage

[hw/rtl/lasm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_cell
// One query row: holds its symbol and score, updates the score as the
// reference wavefront passes and hands the wave on to the next row.
// ----------------------------------------------------------------------------
module lasm_cell
  import lasm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic               active,
  input  logic               wr_sym,
  input  logic [SYM_W-1:0]   sym_in,
  input  wave_t              wave_in,
  output wave_t              wave_out,
  input  logic [SCORE_W-1:0] out_in,
  output logic [SCORE_W-1:0] out_q
);

  logic [SYM_W-1:0]          sym;
  logic [SCORE_W-1:0]        score;
  logic                      wave_valid;
  logic [SYM_W-1:0]          wave_sym;
  logic [SCORE_W-1:0]        wave_diag;
  logic [SCORE_W-1:0]        wave_above;
  logic signed [CALC_W-1:0]  sim;
  logic signed [CALC_W-1:0]  gap_ext;
  logic signed [CALC_W-1:0]  diag_sum;
  logic signed [CALC_W-1:0]  up_sum;
  logic signed [CALC_W-1:0]  left_sum;
  logic signed [CALC_W-1:0]  best_raw;
  logic [SCORE_W-1:0]        best;
  logic                      update;

  assign update = wave_in.valid && active;

  // cell recurrence: max of zero, diagonal plus similarity, up and left plus gap
  always_comb begin
    sim      = (sym == wave_in.ref_sym)
               ? $signed({{(CALC_W-MATCH_W){1'b0}}, ctl.match})
               : $signed({{(CALC_W-PEN_W){ctl.mismatch[PEN_W-1]}}, ctl.mismatch});
    gap_ext  = $signed({{(CALC_W-PEN_W){ctl.gap[PEN_W-1]}}, ctl.gap});
    diag_sum = $signed({2'b00, wave_in.diag}) + sim;
    up_sum   = $signed({2'b00, wave_in.above}) + gap_ext;
    left_sum = $signed({2'b00, score}) + gap_ext;
    best_raw = '0;
    if (diag_sum > best_raw) begin
      best_raw = diag_sum;
    end
    if (up_sum > best_raw) begin
      best_raw = up_sum;
    end
    if (left_sum > best_raw) begin
      best_raw = left_sum;
    end
    if (best_raw > $signed(CALC_W'(SCORE_CAP))) begin
      best = SCORE_W'(SCORE_CAP);
    end else begin
      best = best_raw[SCORE_W-1:0];
    end
  end

  // query symbol
  always_ff @(posedge clk) begin
    if (wr_sym) begin
      sym <= sym_in;
    end
  end

  // row score
  always_ff @(posedge clk) begin
    if (rst) begin
      score <= '0;
    end else if (ctl.clear) begin
      score <= '0;
    end else if (update) begin
      score <= best;
    end
  end

  // wave hand-off to the next row
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_valid <= 1'b0;
    end else begin
      wave_valid <= update;
    end
  end

  always_ff @(posedge clk) begin
    wave_sym   <= wave_in.ref_sym;
    wave_diag  <= score;
    wave_above <= best;
  end

  assign wave_out = '{valid: wave_valid, ref_sym: wave_sym, diag: wave_diag,
                      above: wave_above};

  // unload shift register, moves towards row one
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_q <= score;
    end else if (ctl.shift_out) begin
      out_q <= out_in;
    end
  end

endmodule

[hw/rtl/lasm_array.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lasm_array
// The row of query cells, with the wave chain running from row one down
// and the unload chain running back up to row one.
// ----------------------------------------------------------------------------
module lasm_array
  import lasm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [LEN_W-1:0]   query_len,
  input  logic               append,
  input  logic [SYM_W-1:0]   sym_in,
  input  wave_t              wave_head,
  output logic [SCORE_W-1:0] out_head
);

  wave_t              wave_link [0:MAX_QUERY_LEN];
  logic [SCORE_W-1:0] out_link  [0:MAX_QUERY_LEN];

  assign wave_link[0]             = wave_head;
  assign out_link[MAX_QUERY_LEN]  = '0;
  assign out_head                 = out_link[0];

  // one cell per query row
  for (genvar i = 0; i < MAX_QUERY_LEN; i++) begin : g_row
    logic active;
    logic wr_sym;

    assign active = LEN_W'(i) < query_len;
    assign wr_sym = append && (query_len == LEN_W'(i));

    lasm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .active   (active),
      .wr_sym   (wr_sym),
      .sym_in   (sym_in),
      .wave_in  (wave_link[i]),
      .wave_out (wave_link[i+1]),
      .out_in   (out_link[i+1]),
      .out_q    (out_link[i])
    );
  end

endmodule

[hw/rtl/local_alignment_score_matrix_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_alignment_score_matrix_top
// Smith-Waterman score column fill with a linear gap, one cell per query row.
// ----------------------------------------------------------------------------
// A reference item launches a wavefront down the chain of row cells, one
// row per cycle, and holds in_ready low until the wave has passed every
// occupied row. With the end mark set, a load step follows and then the
// final column leaves row by row, one score per cycle while out_ready is
// high, after which new items are taken again. A reference item on an
// empty query launches no wave and gives no result.
// Configuration is written through cfg_write / cfg_index / cfg_data and
// applies at once.
// ----------------------------------------------------------------------------
module local_alignment_score_matrix_top
  import lasm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PEN_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [SYM_W-1:0]     symbol,
  input  logic                 end_of_reference,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEN_W-1:0]     row_index,
  output logic [SCORE_W-1:0]   score,
  output logic                 last_row
);

  state_t             state;
  state_t             state_next;
  logic [MATCH_W-1:0] match_q;
  logic [PEN_W-1:0]   mismatch_q;
  logic [PEN_W-1:0]   gap_q;
  logic [LEN_W-1:0]   query_len;
  logic [LEN_W-1:0]   cnt;
  logic [LEN_W-1:0]   cnt_inc;
  logic               eor_pend;
  logic               wave_go;
  logic [SYM_W-1:0]   wave_sym;
  logic               accept;
  logic               is_clear;
  logic               is_append;
  logic               is_ref;
  logic               full;
  logic               load_out;
  logic               move;
  cell_ctl_t          ctl;
  wave_t              wave_head;
  logic [SCORE_W-1:0] out_head;

  // item decode
  assign accept    = in_valid && in_ready;
  assign is_clear  = opcode_t'(opcode) == OP_CLEAR;
  assign is_append = opcode_t'(opcode) == OP_APPEND;
  assign is_ref    = opcode_t'(opcode) == OP_REFERENCE;
  assign full      = query_len == LEN_W'(MAX_QUERY_LEN);
  assign cnt_inc   = cnt + LEN_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      match_q    <= MATCH_W'(2);
      mismatch_q <= '1;
      gap_q      <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MATCH:    match_q    <= cfg_data[MATCH_W-1:0];
        CFG_MISMATCH: mismatch_q <= cfg_data;
        CFG_GAP:      gap_q      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    move       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && is_ref && (query_len != '0)) begin
          state_next = ST_WAVE;
        end
      end
      ST_WAVE: begin
        if (cnt == query_len) begin
          state_next = eor_pend ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: begin
        load_out   = 1'b1;
        state_next = ST_UNLOAD;
      end
      ST_UNLOAD: begin
        move = !out_valid || out_ready;
        if (move && (cnt_inc == query_len)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // row counter for the wave and the unload
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (state)
        ST_IDLE:   cnt <= '0;
        ST_WAVE:   cnt <= cnt_inc;
        ST_LOAD:   cnt <= '0;
        ST_UNLOAD: if (move) cnt <= cnt_inc;
        default:   cnt <= '0;
      endcase
    end
  end

  // query length
  always_ff @(posedge clk) begin
    if (rst) begin
      query_len <= '0;
    end else if (accept && is_clear) begin
      query_len <= '0;
    end else if (accept && is_append && !full) begin
      query_len <= query_len + LEN_W'(1);
    end
  end

  // wave launch into row one
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_go  <= 1'b0;
      eor_pend <= 1'b0;
    end else begin
      wave_go <= accept && is_ref && (query_len != '0);
      if (accept) begin
        eor_pend <= is_ref && end_of_reference;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wave_sym <= symbol;
    end
  end

  assign wave_head = '{valid: wave_go, ref_sym: wave_sym, diag: '0, above: '0};

  assign ctl = '{clear: accept && is_clear, load_out: load_out, shift_out: move,
                 match: match_q, mismatch: mismatch_q, gap: gap_q};

  lasm_array u_array (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .query_len (query_len),
    .append    (accept && is_append && !full),
    .sym_in    (symbol),
    .wave_head (wave_head),
    .out_head  (out_head)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      row_index <= cnt_inc;
      score     <= out_head;
      last_row  <= cnt_inc == query_len;
    end
  end

`ifndef SYNTH
  // query never grows beyond the chain
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    query_len <= LEN_W'(MAX_QUERY_LEN))
    else $error("query length beyond chain");

  // a wave is only launched into a non-empty query
  a_wave_nonempty: assert property (@(posedge clk) disable iff (rst)
    wave_go |-> query_len != '0)
    else $error("wave launched on empty query");

  // wave counter stays within the active rows
  a_wave_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAVE |-> cnt <= query_len)
    else $error("wave counter overran query");

  // rows of a column follow without a gap when the sink takes them
  a_rows_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_row |=> out_valid)
    else $error("gap inside emitted column");

  // no item taken while a column is still leaving
  a_no_input_mid_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> !in_ready)
    else $error("item taken mid column");
`endif

endmodule
